### hw/rtl/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

   localparam int LEVEL_WIDTH = 15;
   localparam int STEP_WIDTH = 15;
   localparam int SUSTAIN_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 15;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int ENVELOPE_WIDTH = 16;
   localparam int CALC_WIDTH = ((LEVEL_WIDTH > STEP_WIDTH) ? LEVEL_WIDTH : STEP_WIDTH) + 1;

   localparam logic [STEP_WIDTH-1:0] ATTACK_STEP_RESET = STEP_WIDTH'(256);
   localparam logic [STEP_WIDTH-1:0] DECAY_STEP_RESET = STEP_WIDTH'(256);
   localparam logic [SUSTAIN_WIDTH-1:0] SUSTAIN_LEVEL_RESET = SUSTAIN_WIDTH'(128);
   localparam logic [STEP_WIDTH-1:0] RELEASE_STEP_RESET = STEP_WIDTH'(256);

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_ATTACK  = 2'd1,
      PH_DECAY   = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ATTACK_STEP   = 2'd0,
      CSR_DECAY_STEP    = 2'd1,
      CSR_SUSTAIN_LEVEL = 2'd2,
      CSR_RELEASE_STEP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [STEP_WIDTH-1:0]    attack_step;
      logic [STEP_WIDTH-1:0]    decay_step;
      logic [SUSTAIN_WIDTH-1:0] sustain_level;
      logic [STEP_WIDTH-1:0]    release_step;
   } env_config_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      phase_type              phase;
      logic                   prev_gate;
   } env_state_type;

endpackage

`default_nettype wire

### hw/rtl/adsr_env_step.sv
`default_nettype none

module adsr_env_step (
   input  var adsr_pkg::env_config_type cfg,
   input  var adsr_pkg::env_state_type  state,
   input  wire logic                    gate,
   output adsr_pkg::env_state_type      next_state
);

   localparam int CW = adsr_pkg::CALC_WIDTH;
   localparam int LW = adsr_pkg::LEVEL_WIDTH;

   logic [CW-1:0]       level_ext;
   logic [CW-1:0]       full_ext;
   logic [CW-1:0]       sus_ext;
   logic [CW-1:0]       attack_ext;
   logic [CW-1:0]       decay_ext;
   logic [CW-1:0]       release_ext;
   logic [CW-1:0]       attack_sum;
   logic [CW-1:0]       decay_diff;
   logic [CW-1:0]       release_diff;
   adsr_pkg::phase_type phase_gated;
   adsr_pkg::phase_type phase_next;
   logic [CW-1:0]       level_next;

   assign level_ext = CW'(state.level);
   assign full_ext = CW'({LW{1'b1}});
   assign sus_ext = CW'({cfg.sustain_level, {(LW - adsr_pkg::SUSTAIN_WIDTH){1'b0}}});
   assign attack_ext = CW'(cfg.attack_step);
   assign decay_ext = CW'(cfg.decay_step);
   assign release_ext = CW'(cfg.release_step);
   assign attack_sum = level_ext + attack_ext;
   assign decay_diff = level_ext - decay_ext;
   assign release_diff = level_ext - release_ext;

   always_comb begin
      phase_gated = state.phase;
      if (gate && !state.prev_gate) begin
         phase_gated = adsr_pkg::PH_ATTACK;
      end else if (!gate && state.prev_gate) begin
         phase_gated = adsr_pkg::PH_RELEASE;
      end

      phase_next = phase_gated;
      level_next = level_ext;
      unique case (phase_gated)
         adsr_pkg::PH_IDLE: begin
            level_next = '0;
         end
         adsr_pkg::PH_ATTACK: begin
            if (attack_sum > full_ext) begin
               level_next = full_ext;
               phase_next = adsr_pkg::PH_DECAY;
            end else begin
               level_next = attack_sum;
            end
         end
         adsr_pkg::PH_DECAY: begin
            if (level_ext < decay_ext || decay_diff <= sus_ext) begin
               level_next = sus_ext;
            end else begin
               level_next = decay_diff;
            end
         end
         adsr_pkg::PH_RELEASE: begin
            if (level_ext < release_ext) begin
               level_next = '0;
               phase_next = adsr_pkg::PH_IDLE;
            end else begin
               level_next = release_diff;
            end
         end
      endcase

      next_state.level = level_next[LW-1:0];
      next_state.phase = phase_next;
      next_state.prev_gate = gate;
   end

endmodule

`default_nettype wire

### hw/rtl/adsr_envelope_generator_core.sv
`default_nettype none

// Linear ADSR envelope generator. Each req beat is one tick carrying the gate bit; each
// tick yields exactly one rsp beat with the envelope (level shifted left by one) and the
// phase after the tick. One tick is taken per clock while req_stall is low: the level
// update is a single add or subtract and compare from the last tick's level, registered
// once into the output stage. A two-deep output (result and skid registers) lets req keep
// flowing while a result waits; req_stall rises only when both are full. Step and
// sustain registers are written through the csr port and should only change while idle.

module adsr_envelope_generator_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [adsr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [adsr_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_gate,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [adsr_pkg::ENVELOPE_WIDTH-1:0]         rsp_envelope,
   output logic [1:0]                                  rsp_phase
);

   localparam int LW = adsr_pkg::LEVEL_WIDTH;
   localparam int EW = adsr_pkg::ENVELOPE_WIDTH;
   localparam int XW = ((LW + 1) > EW) ? (LW + 1) : EW;

   adsr_pkg::env_config_type cfg_ff;
   adsr_pkg::env_state_type  state_ff;
   adsr_pkg::env_state_type  state_in;
   adsr_pkg::csr_index_type  csr_code;

   logic             out_valid_ff;
   logic             skid_valid_ff;
   logic [EW-1:0]    out_env_ff;
   logic [1:0]       out_phase_ff;
   logic [EW-1:0]    skid_env_ff;
   logic [1:0]       skid_phase_ff;
   logic [EW-1:0]    new_env;
   logic [XW-1:0]    env_wide;
   logic             accept;
   logic             out_free;

   assign csr_code = adsr_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_step <= adsr_pkg::ATTACK_STEP_RESET;
         cfg_ff.decay_step <= adsr_pkg::DECAY_STEP_RESET;
         cfg_ff.sustain_level <= adsr_pkg::SUSTAIN_LEVEL_RESET;
         cfg_ff.release_step <= adsr_pkg::RELEASE_STEP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_code)
            adsr_pkg::CSR_ATTACK_STEP: begin
               cfg_ff.attack_step <= csr_write_data[adsr_pkg::STEP_WIDTH-1:0];
            end
            adsr_pkg::CSR_DECAY_STEP: begin
               cfg_ff.decay_step <= csr_write_data[adsr_pkg::STEP_WIDTH-1:0];
            end
            adsr_pkg::CSR_SUSTAIN_LEVEL: begin
               cfg_ff.sustain_level <= csr_write_data[adsr_pkg::SUSTAIN_WIDTH-1:0];
            end
            adsr_pkg::CSR_RELEASE_STEP: begin
               cfg_ff.release_step <= csr_write_data[adsr_pkg::STEP_WIDTH-1:0];
            end
         endcase
      end
   end

   adsr_env_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .gate       (req_gate),
      .next_state (state_in)
   );

   assign accept = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign env_wide = XW'({state_in.level, 1'b0});
   assign new_env = env_wide[EW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.level <= '0;
         state_ff.phase <= adsr_pkg::PH_IDLE;
         state_ff.prev_gate <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload path, no reset
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_env_ff <= skid_env_ff;
            out_phase_ff <= skid_phase_ff;
         end else if (accept) begin
            out_env_ff <= new_env;
            out_phase_ff <= state_in.phase;
         end
      end else if (accept) begin
         skid_env_ff <= new_env;
         skid_phase_ff <= state_in.phase;
      end
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_envelope = out_env_ff;
   assign rsp_phase = out_phase_ff;

endmodule

`default_nettype wire
